>>> hdl/lpc_residual_filter_macros.svh
// assertion helpers shared by the filter rtl
`ifndef LPC_RESIDUAL_FILTER_MACROS_SVH
`define LPC_RESIDUAL_FILTER_MACROS_SVH

// same-cycle implication, off while reset is high
`define LRF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define LRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lrf_pkg.sv
`default_nettype none

package lrf_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int COEF_W     = 32;
   localparam int ACC_W      = 64;
   localparam int ORDER_W    = 6;
   localparam int QSHIFT_W   = 5;
   localparam int TAP_IDX_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic OP_COEF   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic MODE_ANALYSIS  = 1'b0;
   localparam logic MODE_SYNTHESIS = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QSHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 2'd2;

   localparam logic [QSHIFT_W-1:0] QSHIFT_RESET = 5'd15;

   typedef logic signed [SAMPLE_W-1:0] lrf_sample_type;
   typedef logic signed [COEF_W-1:0]   lrf_coef_type;
   typedef logic signed [ACC_W-1:0]    lrf_acc_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_ROUND,
      ST_SHIFT,
      ST_DONE
   } lrf_state_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } lrf_mac_ctrl_type;

endpackage

`default_nettype wire

>>> hdl/lrf_req_if.sv
`default_nettype none

interface lrf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic [lrf_pkg::TAP_IDX_W-1:0]       coef_index;
   lrf_pkg::lrf_coef_type               coef_value;
   lrf_pkg::lrf_sample_type             sample_value;
   logic                                block_start;

   modport source (
      output valid, op, coef_index, coef_value, sample_value, block_start,
      input  ready
   );
   modport sink (
      input  valid, op, coef_index, coef_value, sample_value, block_start,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/lrf_rsp_if.sv
`default_nettype none

interface lrf_rsp_if;
   logic                    valid;
   logic                    ready;
   lrf_pkg::lrf_sample_type out_value;

   modport source (output valid, out_value, input ready);
   modport sink (input valid, out_value, output ready);
endinterface

`default_nettype wire

>>> hdl/lpc_residual_filter.sv
`default_nettype none

// lpc residual / reconstruction filter
// req_ch (valid/ready) carries one item: op selects a coefficient write (tap
// coef_index, 1..TAP_DEPTH, value coef_value) or a sample item (sample_value,
// block_start clears the history first). rsp_ch returns one out_value per
// sample item, in order; coefficient writes give no item.
// csr_* writes order, qshift and mode, one register per cycle; the user must
// write them only while idle, the block does not enforce it. a coefficient
// write is taken while idle and leaves the block idle. a sample item holds
// req_ch not ready from accept until its output load: one shared 32x32
// multiplier walks the taps (min(order, TAP_DEPTH)) one per cycle, then the
// read and product registers drain, then come the rounding add, the
// arithmetic shift and the output load, which raises rsp_valid.
// reset (synchronous, active high) clears the tables and history to zero via
// valid bits, sets order 0, qshift 15, mode analysis; no clearing pass.
// the result sits in an output register; if the receiver stalls the block
// holds the finished result internally until the register frees up, and
// req_ch stays not ready meanwhile.
module lpc_residual_filter #(
   parameter int TAP_DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lrf_req_if.sink                            req_ch,
   lrf_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [lrf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lrf_pkg::CSR_DATA_W-1:0] csr_wdata
);

`include "lpc_residual_filter_macros.svh"

   localparam int AW = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
   localparam int CW = $clog2(TAP_DEPTH + 1);
   localparam int XW = 7; // wide enough for any tap number and TAP_DEPTH

   localparam logic [AW-1:0] LAST_SLOT = AW'(TAP_DEPTH - 1);

   // configuration
   logic [lrf_pkg::ORDER_W-1:0]  order_ff, order_in;
   logic [lrf_pkg::QSHIFT_W-1:0] qshift_ff, qshift_in;
   logic                         mode_ff, mode_in;

   // sequencer
   lrf_pkg::lrf_state_type state_ff, state_in;
   logic [CW-1:0]          tap_cnt_ff, tap_cnt_in;
   logic [CW-1:0]          taps_ff, taps_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic                   rd_vld_ff, rd_vld_in;

   // valid bits standing in for the zero reset of both tables
   logic [TAP_DEPTH-1:0] coef_vld_ff, coef_vld_in;
   logic [TAP_DEPTH-1:0] hist_vld_ff, hist_vld_in;
   logic                 coef_rv_ff, coef_rv_in;
   logic                 hist_rv_ff, hist_rv_in;

   // datapath
   lrf_pkg::lrf_sample_type sample_ff, sample_in;
   lrf_pkg::lrf_acc_type    total_ff, total_in;
   lrf_pkg::lrf_sample_type res_ff, res_in;
   lrf_pkg::lrf_sample_type rsp_data_ff, rsp_data_in;
   logic                    rsp_vld_ff, rsp_vld_in;

   // control
   logic req_ready;
   logic req_accept;
   logic accept_coef;
   logic accept_sample;
   logic issue;
   logic load_rsp;
   logic taps_done;
   logic coef_idx_ok;

   lrf_pkg::lrf_mac_ctrl_type mac_ctrl;
   lrf_pkg::lrf_acc_type      mac_acc;
   logic                      mac_busy;

   // memories
   logic [AW-1:0]              coef_waddr;
   logic [lrf_pkg::COEF_W-1:0] coef_rdata;
   logic [lrf_pkg::SAMPLE_W-1:0] hist_rdata;
   logic                       hist_we;
   lrf_pkg::lrf_sample_type    hist_wdata;

   lrf_pkg::lrf_coef_type   coef_op;
   lrf_pkg::lrf_sample_type hist_op;
   lrf_pkg::lrf_acc_type    round_val;
   lrf_pkg::lrf_acc_type    shifted;
   logic [AW-1:0]           newest_ptr;
   logic [AW-1:0]           rd_ptr_dec;
   logic [AW-1:0]           wr_ptr_inc;

   assign req_accept    = req_ch.valid && req_ready;
   assign accept_coef   = req_accept && (req_ch.op == lrf_pkg::OP_COEF);
   assign accept_sample = req_accept && (req_ch.op == lrf_pkg::OP_SAMPLE);
   assign taps_done     = (tap_cnt_ff == taps_ff);

   // tap numbers outside 1..TAP_DEPTH are dropped
   assign coef_idx_ok = (req_ch.coef_index != '0)
                     && (XW'(req_ch.coef_index) <= XW'(TAP_DEPTH));
   assign coef_waddr  = AW'(req_ch.coef_index - 1'b1);

   // circular history: wr_ptr is the next free slot, newest sits just behind
   assign newest_ptr = (wr_ptr_ff == '0) ? LAST_SLOT : AW'(wr_ptr_ff - 1'b1);
   assign rd_ptr_dec = (rd_ptr_ff == '0) ? LAST_SLOT : AW'(rd_ptr_ff - 1'b1);
   assign wr_ptr_inc = (wr_ptr_ff == LAST_SLOT) ? '0 : AW'(wr_ptr_ff + 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrf_pkg::ST_IDLE: begin
            if (accept_sample) begin
               state_in = lrf_pkg::ST_MAC;
            end
         end
         lrf_pkg::ST_MAC: begin
            if (taps_done && !rd_vld_ff && !mac_busy) begin
               state_in = lrf_pkg::ST_ROUND;
            end
         end
         lrf_pkg::ST_ROUND: state_in = lrf_pkg::ST_SHIFT;
         lrf_pkg::ST_SHIFT: state_in = lrf_pkg::ST_DONE;
         lrf_pkg::ST_DONE: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               state_in = lrf_pkg::ST_IDLE;
            end
         end
         default: state_in = lrf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      issue          = 1'b0;
      load_rsp       = 1'b0;
      unique case (state_ff)
         lrf_pkg::ST_IDLE:  req_ready = 1'b1;
         lrf_pkg::ST_MAC:   issue     = !taps_done;
         lrf_pkg::ST_ROUND: ;
         lrf_pkg::ST_SHIFT: ;
         lrf_pkg::ST_DONE:  load_rsp  = !rsp_vld_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign mac_ctrl.clear = accept_sample;
   assign mac_ctrl.valid = rd_vld_ff;

   // configuration writes
   always_comb begin
      order_in  = order_ff;
      qshift_in = qshift_ff;
      mode_in   = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            lrf_pkg::REG_ORDER:  order_in  = csr_wdata[lrf_pkg::ORDER_W-1:0];
            lrf_pkg::REG_QSHIFT: qshift_in = csr_wdata[lrf_pkg::QSHIFT_W-1:0];
            lrf_pkg::REG_MODE:   mode_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // tap walk
   always_comb begin
      tap_cnt_in = tap_cnt_ff;
      taps_in    = taps_ff;
      rd_ptr_in  = rd_ptr_ff;
      sample_in  = sample_ff;
      rd_vld_in  = issue;
      coef_rv_in = coef_vld_ff[tap_cnt_ff[AW-1:0]];
      hist_rv_in = hist_vld_ff[rd_ptr_ff];
      if (accept_sample) begin
         tap_cnt_in = '0;
         rd_ptr_in  = newest_ptr;
         sample_in  = req_ch.sample_value;
         // orders above TAP_DEPTH use every tap
         if (XW'(order_ff) > XW'(TAP_DEPTH)) begin
            taps_in = CW'(TAP_DEPTH);
         end else begin
            taps_in = CW'(order_ff);
         end
      end else if (issue) begin
         tap_cnt_in = CW'(tap_cnt_ff + 1'b1);
         rd_ptr_in  = rd_ptr_dec;
      end
   end

   // unwritten coefficients and cleared history read as zero
   assign coef_op = coef_rv_ff ? lrf_pkg::lrf_coef_type'(coef_rdata) : '0;
   assign hist_op = hist_rv_ff ? lrf_pkg::lrf_sample_type'(hist_rdata) : '0;

   // rounding constant half an lsb of the result; none when qshift is zero
   assign round_val = (qshift_ff == '0) ? '0
                    : lrf_pkg::lrf_acc_type'(64'd1 << (qshift_ff - 1'b1));
   assign shifted   = total_ff >>> qshift_ff;

   always_comb begin
      total_in = total_ff;
      res_in   = res_ff;
      if (state_ff == lrf_pkg::ST_ROUND) begin
         if (mode_ff == lrf_pkg::MODE_ANALYSIS) begin
            total_in = round_val + mac_acc;
         end else begin
            total_in = round_val - mac_acc;
         end
      end
      if (state_ff == lrf_pkg::ST_SHIFT) begin
         res_in = sample_ff - lrf_pkg::lrf_sample_type'(shifted[lrf_pkg::SAMPLE_W-1:0]);
      end
   end

   // history update and result hand-off
   assign hist_we    = load_rsp;
   assign hist_wdata = (mode_ff == lrf_pkg::MODE_ANALYSIS) ? sample_ff : res_ff;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      coef_vld_in = coef_vld_ff;
      hist_vld_in = hist_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff;
      if (accept_coef && coef_idx_ok) begin
         coef_vld_in[coef_waddr] = 1'b1;
      end
      if (accept_sample && req_ch.block_start) begin
         hist_vld_in = '0;
      end
      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (load_rsp) begin
         hist_vld_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in              = wr_ptr_inc;
         rsp_data_in            = res_ff;
         rsp_vld_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lrf_pkg::ST_IDLE;
         order_ff    <= '0;
         qshift_ff   <= lrf_pkg::QSHIFT_RESET;
         mode_ff     <= lrf_pkg::MODE_ANALYSIS;
         tap_cnt_ff  <= '0;
         taps_ff     <= '0;
         wr_ptr_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         order_ff    <= order_in;
         qshift_ff   <= qshift_in;
         mode_ff     <= mode_in;
         tap_cnt_ff  <= tap_cnt_in;
         taps_ff     <= taps_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_vld_ff   <= rd_vld_in;
         coef_vld_ff <= coef_vld_in;
         hist_vld_ff <= hist_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      coef_rv_ff  <= coef_rv_in;
      hist_rv_ff  <= hist_rv_in;
      sample_ff   <= sample_in;
      total_ff    <= total_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   lrf_ram #(
      .WIDTH (lrf_pkg::COEF_W),
      .DEPTH (TAP_DEPTH)
   ) u_coef_ram (
      .clock (clock),
      .we    (accept_coef && coef_idx_ok),
      .waddr (coef_waddr),
      .wdata (req_ch.coef_value),
      .raddr (tap_cnt_ff[AW-1:0]),
      .rdata (coef_rdata)
   );

   lrf_ram #(
      .WIDTH (lrf_pkg::SAMPLE_W),
      .DEPTH (TAP_DEPTH)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (wr_ptr_ff),
      .wdata (hist_wdata),
      .raddr (rd_ptr_ff),
      .rdata (hist_rdata)
   );

   lrf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  (coef_op),
      .hist  (hist_op),
      .acc   (mac_acc),
      .busy  (mac_busy)
   );

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.out_value = rsp_data_ff;

   `LRF_ASSERT_NEXT(a_sample_starts_walk, clock, reset, accept_sample, state_ff == lrf_pkg::ST_MAC, "sample item did not start the tap walk")
   `LRF_ASSERT_IMPLY(a_tap_cnt_bound, clock, reset, state_ff == lrf_pkg::ST_MAC, tap_cnt_ff <= taps_ff, "tap counter ran past the order")
   `LRF_ASSERT_IMPLY(a_mac_drained, clock, reset, state_ff == lrf_pkg::ST_ROUND, !rd_vld_ff && !mac_busy, "rounding started with products still in flight")
   `LRF_ASSERT_IMPLY(a_wr_ptr_range, clock, reset, 1'b1, XW'(wr_ptr_ff) < XW'(TAP_DEPTH), "history pointer out of range")
   `LRF_ASSERT_NEXT(a_load_sets_valid, clock, reset, load_rsp, rsp_vld_ff, "result load did not raise the output valid")

endmodule

`default_nettype wire

>>> hdl/lrf_ram.sv
`default_nettype none

module lrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> hdl/lrf_mac.sv
`default_nettype none

// shared multiply-accumulate: product register, then 64-bit wrapping sum
module lrf_mac (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lrf_pkg::lrf_mac_ctrl_type ctrl,
   input  wire lrf_pkg::lrf_coef_type     coef,
   input  wire lrf_pkg::lrf_sample_type   hist,
   output lrf_pkg::lrf_acc_type           acc,
   output logic                           busy
);

   lrf_pkg::lrf_acc_type prod_ff, prod_in;
   lrf_pkg::lrf_acc_type acc_ff, acc_in;
   logic                 prod_vld_ff, prod_vld_in;

   always_comb begin
      prod_in     = lrf_pkg::lrf_acc_type'(coef) * lrf_pkg::lrf_acc_type'(hist);
      prod_vld_in = ctrl.valid && !ctrl.clear;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_vld_ff;

endmodule

`default_nettype wire
